>>> design/sbrr_pkg.sv
// Shared types and constants of the skip-and-backoff round-robin selector.
`default_nettype none

package sbrr_pkg;

  localparam int CV_W        = 16;
  localparam int COUNT_W     = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;
  localparam int CV_REG_NUM  = 4;

  // command codes carried on s_tuser
  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CV_0      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ENTRIES   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SKIP  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> design/sbrr_skip_unit.sv
// Shared skip arithmetic: backoff growth or clear, count compare and count increment.
`default_nettype none

module sbrr_skip_unit #(
  parameter int SKIP_WIDTH = 8
) (
  input  wire logic [SKIP_WIDTH-1:0] amount,
  input  wire logic [SKIP_WIDTH-1:0] count,
  input  wire logic [SKIP_WIDTH-1:0] cap,
  input  wire logic                  grow,
  output logic      [SKIP_WIDTH-1:0] upd_amount,
  output logic                       below,
  output logic      [SKIP_WIDTH-1:0] count_inc
);

  logic [SKIP_WIDTH:0] dbl;
  logic [SKIP_WIDTH:0] cap_ext;

  always_comb begin
    cap_ext = {1'b0, cap};
    dbl     = {amount, 1'b0};
    if (amount == '0) begin
      dbl = (SKIP_WIDTH+1)'(1);
    end
    if (dbl > cap_ext) begin
      dbl = cap_ext;
    end
    if (!grow) begin
      upd_amount = '0;
    end else if (amount < cap) begin
      upd_amount = dbl[SKIP_WIDTH-1:0];
    end else begin
      upd_amount = amount;
    end
  end

  assign below     = count < amount;
  assign count_inc = count + SKIP_WIDTH'(1);

endmodule

`default_nettype wire

>>> design/skip_backoff_round_robin_selector.sv
// Top level of the skip-and-backoff round-robin selector.
// Sequence: an update scans the entries in use for the reported voltage, an advance
//   walks them from the current index; both then pass the finish state into the output
//   register, and a disabled block goes straight to finish. One transaction in flight:
//   the sequencer reads one entry a cycle through the shared skip unit.
// Reset: synchronous active-high; clears tables and index, loads config defaults.
`default_nettype none

module skip_backoff_round_robin_selector #(
  parameter int NUM_CV     = 4,
  parameter int SKIP_WIDTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // config write port
  input  wire logic                               cfg_we,
  input  wire logic [sbrr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [sbrr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // s_tdata: report_cv[15:0], prec_count[31:16]
  input  wire logic [sbrr_pkg::IN_DATA_W-1:0]     s_tdata,
  // s_tuser: cmd[0]
  input  wire logic                               s_tuser,
  // output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // m_tdata: selected_cv[15:0], selected_index[17:16], entry_skip_amount[25:18],
  //          cv_found[26], all_skipped[27], zero[31:28]
  output logic      [sbrr_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int IDX_W   = (NUM_CV > 1) ? $clog2(NUM_CV) : 1;
  localparam int CNT_W   = $clog2(NUM_CV + 1);
  localparam int EW      = (CNT_W > 3) ? CNT_W : 3;
  localparam int CAP_W   = (SKIP_WIDTH > 8) ? SKIP_WIDTH : 8;
  localparam int PW      = (IDX_W > 2) ? IDX_W : 2;
  localparam logic [CAP_W-1:0] SKIP_MAX = CAP_W'((32'd1 << SKIP_WIDTH) - 32'd1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sbrr_pkg::CV_W-1:0]    cv_value [NUM_CV];
  logic [2:0]                   entries_used;
  logic [7:0]                   max_skip;
  logic [sbrr_pkg::COUNT_W-1:0] threshold;
  logic                         enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CV; i++) begin
        cv_value[i] <= '0;
      end
      entries_used <= 3'd1;
      max_skip     <= 8'd8;
      threshold    <= '0;
      enabled      <= 1'b0;
    end else if (cfg_we) begin
      // only the first four entries have a voltage register; the rest stay at zero
      for (int i = 0; i < NUM_CV; i++) begin
        if (i < sbrr_pkg::CV_REG_NUM &&
            cfg_addr == sbrr_pkg::REG_CV_0 + sbrr_pkg::CFG_ADDR_W'(i)) begin
          cv_value[i] <= cfg_wdata;
        end
      end
      case (cfg_addr)
        sbrr_pkg::REG_ENTRIES:   entries_used <= cfg_wdata[2:0];
        sbrr_pkg::REG_MAX_SKIP:  max_skip     <= cfg_wdata[7:0];
        sbrr_pkg::REG_THRESHOLD: threshold    <= cfg_wdata;
        sbrr_pkg::REG_ENABLE:    enabled      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective entry count: zero acts as one, saturates at the table size
  logic [EW-1:0]    ceu;
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    ceu = EW'(entries_used);
    if (ceu == '0) begin
      n_eff = CNT_W'(1);
    end else if (ceu > EW'(NUM_CV)) begin
      n_eff = CNT_W'(NUM_CV);
    end else begin
      n_eff = ceu[CNT_W-1:0];
    end
  end

  // Skip cap: max_skip, limited to what a skip amount can hold
  logic [CAP_W-1:0]      cap_w;
  logic [SKIP_WIDTH-1:0] cap;
  always_comb begin
    cap_w = (CAP_W'(max_skip) < SKIP_MAX) ? CAP_W'(max_skip) : SKIP_MAX;
    cap   = cap_w[SKIP_WIDTH-1:0];
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  sbrr_pkg::state_t state, state_next;

  logic [SKIP_WIDTH-1:0]        skip_amount [NUM_CV];
  logic [SKIP_WIDTH-1:0]        skip_count  [NUM_CV];
  logic [IDX_W-1:0]             cur, cur_next;
  logic [IDX_W-1:0]             ptr, ptr_next;
  logic [CNT_W-1:0]             steps, steps_next;

  logic [sbrr_pkg::CV_W-1:0]    cv_q;
  logic [sbrr_pkg::COUNT_W-1:0] count_q;

  logic [SKIP_WIDTH-1:0]        res_amt, res_amt_next;
  logic                         res_found, res_found_next;
  logic                         res_all, res_all_next;
  logic                         take_amt, take_amt_next;

  logic                         accept;
  logic                         amt_we, cnt_we;
  logic [SKIP_WIDTH-1:0]        cnt_wdata;
  logic                         load_out;

  // Single read port on the tables, addressed by the sequencer pointer
  logic [sbrr_pkg::CV_W-1:0]    rd_cv;
  logic [SKIP_WIDTH-1:0]        rd_amt;
  logic [SKIP_WIDTH-1:0]        rd_cnt;
  assign rd_cv  = cv_value[ptr];
  assign rd_amt = skip_amount[ptr];
  assign rd_cnt = skip_count[ptr];

  logic [SKIP_WIDTH-1:0] upd_amount;
  logic                  below;
  logic [SKIP_WIDTH-1:0] count_inc;

  sbrr_skip_unit #(
    .SKIP_WIDTH (SKIP_WIDTH)
  ) u_skip (
    .amount     (rd_amt),
    .count      (rd_cnt),
    .cap        (cap),
    .grow       (count_q < threshold),
    .upd_amount (upd_amount),
    .below      (below),
    .count_inc  (count_inc)
  );

  // step with wrap at the entries in use; an index beyond them wraps to 0
  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] c,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] s;
    s = CNT_W'(c) + CNT_W'(1);
    return (s >= n) ? '0 : s[IDX_W-1:0];
  endfunction

  logic match, last_scan, last_step;
  assign match     = (rd_cv == cv_q);
  assign last_scan = (CNT_W'(ptr) == n_eff - CNT_W'(1));
  assign last_step = (steps + CNT_W'(1) == n_eff);

  assign s_tready = (state == sbrr_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sbrr_pkg::ST_IDLE: begin
        if (accept) begin
          if (!enabled) begin
            state_next = sbrr_pkg::ST_FINISH;
          end else if (s_tuser == sbrr_pkg::CMD_UPDATE) begin
            state_next = sbrr_pkg::ST_SCAN;
          end else begin
            state_next = sbrr_pkg::ST_WALK;
          end
        end
      end
      sbrr_pkg::ST_SCAN: begin
        if (match || last_scan) begin
          state_next = sbrr_pkg::ST_FINISH;
        end
      end
      sbrr_pkg::ST_WALK: begin
        if (!below || last_step) begin
          state_next = sbrr_pkg::ST_FINISH;
        end
      end
      sbrr_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = sbrr_pkg::ST_IDLE;
        end
      end
      default: state_next = sbrr_pkg::ST_IDLE;
    endcase
  end

  // sequencer controls
  always_comb begin
    ptr_next       = ptr;
    cur_next       = cur;
    steps_next     = steps;
    res_amt_next   = res_amt;
    res_found_next = res_found;
    res_all_next   = res_all;
    take_amt_next  = take_amt;
    amt_we         = 1'b0;
    cnt_we         = 1'b0;
    cnt_wdata      = '0;
    load_out       = 1'b0;
    case (state)
      sbrr_pkg::ST_IDLE: begin
        if (accept) begin
          steps_next     = '0;
          res_amt_next   = '0;
          res_all_next   = 1'b0;
          if (!enabled) begin
            // disabled: report the current entry untouched
            ptr_next       = cur;
            res_found_next = (s_tuser == sbrr_pkg::CMD_ADVANCE);
            take_amt_next  = (s_tuser == sbrr_pkg::CMD_ADVANCE);
          end else if (s_tuser == sbrr_pkg::CMD_UPDATE) begin
            ptr_next       = '0;
            res_found_next = 1'b0;
            take_amt_next  = 1'b0;
          end else begin
            ptr_next       = wrap_next(cur, n_eff);
            res_found_next = 1'b1;
            take_amt_next  = 1'b1;
          end
        end
      end
      sbrr_pkg::ST_SCAN: begin
        if (match) begin
          amt_we         = 1'b1;
          cnt_we         = 1'b1;
          cnt_wdata      = '0;
          res_amt_next   = upd_amount;
          res_found_next = 1'b1;
          ptr_next       = cur;
        end else if (last_scan) begin
          // unknown voltage
          res_amt_next   = '0;
          res_found_next = 1'b0;
          ptr_next       = cur;
        end else begin
          ptr_next       = ptr + IDX_W'(1);
        end
      end
      sbrr_pkg::ST_WALK: begin
        if (below) begin
          cnt_we     = 1'b1;
          cnt_wdata  = count_inc;
          steps_next = steps + CNT_W'(1);
          if (last_step) begin
            // every entry passed over: stay where the walk ended
            cur_next     = ptr;
            res_all_next = 1'b1;
          end else begin
            ptr_next     = wrap_next(ptr, n_eff);
          end
        end else begin
          cur_next = ptr;
        end
      end
      sbrr_pkg::ST_FINISH: begin
        load_out = !m_tvalid || m_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbrr_pkg::ST_IDLE;
      cur       <= '0;
      ptr       <= '0;
      steps     <= '0;
      res_amt   <= '0;
      res_found <= 1'b0;
      res_all   <= 1'b0;
      take_amt  <= 1'b0;
      for (int i = 0; i < NUM_CV; i++) begin
        skip_amount[i] <= '0;
        skip_count[i]  <= '0;
      end
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      ptr       <= ptr_next;
      steps     <= steps_next;
      res_amt   <= res_amt_next;
      res_found <= res_found_next;
      res_all   <= res_all_next;
      take_amt  <= take_amt_next;
      if (amt_we) begin
        skip_amount[ptr] <= upd_amount;
      end
      if (cnt_we) begin
        skip_count[ptr] <= cnt_wdata;
      end
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cv_q    <= s_tdata[15:0];
      count_q <= s_tdata[31:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0]      amt_ext;
  logic [PW-1:0]         idx_ext;
  always_comb begin
    amt_ext = CAP_W'(take_amt ? rd_amt : res_amt);
    idx_ext = PW'(ptr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'd0, res_all, res_found, amt_ext[7:0], idx_ext[1:0], rd_cv};
    end
  end

`ifndef SYNTHESIS
  // one transaction at a time
  a_single_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transaction accepted while busy");

  // a result is only loaded out of the finish state
  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == sbrr_pkg::ST_FINISH))
    else $error("result produced outside finish state");

  // sequencer pointer stays within the table
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state != sbrr_pkg::ST_IDLE) |-> (CNT_W'(ptr) < CNT_W'(NUM_CV)))
    else $error("table pointer out of range");

  // an all-skipped result is an advance result, which always reports found
  a_all_implies_found: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[27]) |-> m_tdata[26])
    else $error("all-skipped flag without found");
`endif

endmodule

`default_nettype wire

>>> tb/tb_skip_backoff_round_robin_selector.sv
// Self-checking testbench for the skip-and-backoff round-robin selector.
`default_nettype none

module tb_skip_backoff_round_robin_selector;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int SETTLE_CYCLES   = 8;    // covers a full walk of four entries, plus margin
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off

  // result fields, lowest bit first: selected_cv, selected_index, entry_skip_amount,
  // cv_found, all_skipped, zero pad
  typedef struct packed {
    logic [3:0]  pad;
    logic        all_skipped;
    logic        cv_found;
    logic [7:0]  skip_amt;
    logic [1:0]  idx;
    logic [15:0] cv;
  } sel_result_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [sbrr_pkg::CFG_ADDR_W-1:0] addr;
    logic [sbrr_pkg::CFG_DATA_W-1:0] wdata;
    logic                            cmd;
    logic [15:0]                     cv;
    logic [15:0]                     cnt;
    logic                            typed;
    sel_result_t                     want;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [sbrr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sbrr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [sbrr_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // report_cv[15:0], prec_count[31:16]
  logic                            s_tuser = 1'b0; // cmd[0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [sbrr_pkg::OUT_DATA_W-1:0] m_tdata;        // see sel_result_t

  skip_backoff_round_robin_selector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #1 clk = ~clk;

  // mirror of the configuration
  logic [15:0] tbl_cv [4];
  logic [2:0]  tbl_entries;
  logic [7:0]  tbl_max_skip;
  logic [15:0] tbl_threshold;
  logic        tbl_enabled;
  // mirror of the selector state
  logic [7:0]  skip_amt [4];
  logic [7:0]  skip_cnt [4];
  logic [1:0]  cur_idx;

  sel_result_t pending_selections [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  function automatic sel_result_t sel(input logic [15:0] cv, input logic [1:0] idx,
                                      input logic [7:0] amt, input logic found,
                                      input logic all);
    sel_result_t r;
    r = '0;
    r.cv = cv;
    r.idx = idx;
    r.skip_amt = amt;
    r.cv_found = found;
    r.all_skipped = all;
    return r;
  endfunction

  // Works out the selector's answer to one transaction and moves the mirror on.
  function automatic sel_result_t predict_selection(input logic cmd, input logic [15:0] cv,
                                                    input logic [15:0] cnt);
    int          n, pos, i, c, grown;
    logic        landed;
    sel_result_t r;
    n = (tbl_entries == 0) ? 1 : (tbl_entries > 4 ? 4 : int'(tbl_entries));
    r = '0;
    if (cmd == sbrr_pkg::CMD_UPDATE) begin
      if (tbl_enabled) begin
        pos = -1;
        for (i = 0; i < n; i++)
          if (pos < 0 && tbl_cv[2'(i)] == cv) pos = i;
        if (pos >= 0) begin
          if (cnt < tbl_threshold) begin
            // double, zero becomes one, capped; an amount at the cap is left alone
            if (skip_amt[2'(pos)] < tbl_max_skip) begin
              grown = int'(skip_amt[2'(pos)]) * 2;
              if (grown == 0) grown = 1;
              if (grown > int'(tbl_max_skip)) grown = int'(tbl_max_skip);
              skip_amt[2'(pos)] = grown[7:0];
            end
          end else begin
            skip_amt[2'(pos)] = '0;
          end
          skip_cnt[2'(pos)] = '0;
          r.skip_amt = skip_amt[2'(pos)];
          r.cv_found = 1'b1;
        end
      end
    end else begin
      r.cv_found = 1'b1;
      if (tbl_enabled) begin
        landed = 1'b0;
        for (i = 0; i < n && !landed; i++) begin
          c = int'(cur_idx) + 1;
          if (c >= n) c = 0;
          cur_idx = c[1:0];
          if (skip_cnt[2'(c)] < skip_amt[2'(c)]) skip_cnt[2'(c)] = skip_cnt[2'(c)] + 8'd1;
          else landed = 1'b1;
        end
        r.all_skipped = !landed;
      end
      r.skip_amt = skip_amt[cur_idx];
    end
    r.cv = tbl_cv[cur_idx];
    r.idx = cur_idx;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_selection(input sel_result_t got);
    sel_result_t want;
    if (pending_selections.size() == 0) begin
      note_mismatch("unexpected result", got, 0);
      return;
    end
    want = pending_selections.pop_front();
    if (got.cv != want.cv) note_mismatch("selected_cv", got.cv, want.cv);
    if (got.idx != want.idx) note_mismatch("selected_index", got.idx, want.idx);
    if (got.skip_amt != want.skip_amt)
      note_mismatch("entry_skip_amount", got.skip_amt, want.skip_amt);
    if (got.cv_found != want.cv_found) note_mismatch("cv_found", got.cv_found, want.cv_found);
    if (got.all_skipped != want.all_skipped)
      note_mismatch("all_skipped", got.all_skipped, want.all_skipped);
    if (got.pad != '0) note_mismatch("tdata pad", got.pad, 0);
  endtask

  // result side: sampled at the edge, before the block's own updates land
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_selection(sel_result_t'(m_tdata));
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offers one transaction, with an optional gap first; valid stays high on return.
  task automatic send_item(input logic cmd, input logic [15:0] cv, input logic [15:0] cnt,
                           input logic typed, input sel_result_t want);
    sel_result_t guess;
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {cnt, cv};
    do @(posedge clk); while (!s_tready);
    guess = predict_selection(cmd, cv, cnt);
    pending_selections.push_back(typed ? want : guess);
  endtask

  // Stops offering, waits for every result, then lets the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_selections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [sbrr_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      sbrr_pkg::REG_ENTRIES:   tbl_entries = data[2:0];
      sbrr_pkg::REG_MAX_SKIP:  tbl_max_skip = data[7:0];
      sbrr_pkg::REG_THRESHOLD: tbl_threshold = data;
      sbrr_pkg::REG_ENABLE:    tbl_enabled = data[0];
      default:                 tbl_cv[2'(addr - sbrr_pkg::REG_CV_0)] = data;
    endcase
  endtask

  task automatic add_write(input logic [sbrr_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [15:0] data);
    stim_row_t r;
    r = '{kind: ROW_WRITE, default: '0};
    r.addr = addr;
    r.wdata = data;
    directed_rows.push_back(r);
  endtask

  task automatic add_item(input logic cmd, input logic [15:0] cv, input logic [15:0] cnt,
                          input logic typed, input sel_result_t want);
    stim_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.cmd = cmd;
    r.cv = cv;
    r.cnt = cnt;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int          k, i, phase, pick;
    logic        cfg_open;
    logic        cmd;
    logic [15:0] cv, cnt, v;
    stim_row_t   r;

    // mirror starts from the reset state
    for (i = 0; i < 4; i++) begin
      tbl_cv[2'(i)] = '0;
      skip_amt[2'(i)] = '0;
      skip_cnt[2'(i)] = '0;
    end
    tbl_entries = 3'd1;
    tbl_max_skip = 8'd8;
    tbl_threshold = '0;
    tbl_enabled = 1'b0;
    cur_idx = '0;

    // directed table; typed expectations only where they are obvious
    // disabled after reset: update ignored, advance holds
    add_item(sbrr_pkg::CMD_UPDATE, 16'h0000, 16'h0000, 1'b1,
             sel(16'h0000, 2'd0, 8'd0, 1'b0, 1'b0));
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b1,
             sel(16'h0000, 2'd0, 8'd0, 1'b1, 1'b0));
    add_write(sbrr_pkg::REG_CV_0,         16'h8000);
    add_write(sbrr_pkg::REG_CV_0 + 3'd1,  16'h7FFF);
    add_write(sbrr_pkg::REG_CV_0 + 3'd2,  16'h0000);
    add_write(sbrr_pkg::REG_CV_0 + 3'd3,  16'hFFFF);
    add_write(sbrr_pkg::REG_ENTRIES,      16'd4);
    add_write(sbrr_pkg::REG_MAX_SKIP,     16'd255);
    add_write(sbrr_pkg::REG_THRESHOLD,    16'hFFFF);
    add_write(sbrr_pkg::REG_ENABLE,       16'd1);
    // unknown voltage
    add_item(sbrr_pkg::CMD_UPDATE, 16'h1234, 16'h0000, 1'b1,
             sel(16'h8000, 2'd0, 8'd0, 1'b0, 1'b0));
    // below threshold: zero becomes one, then doubles
    add_item(sbrr_pkg::CMD_UPDATE, 16'h8000, 16'h0000, 1'b1,
             sel(16'h8000, 2'd0, 8'd1, 1'b1, 1'b0));
    add_item(sbrr_pkg::CMD_UPDATE, 16'h8000, 16'h7FFE, 1'b0, '0);
    // at the threshold: cleared
    add_item(sbrr_pkg::CMD_UPDATE, 16'h7FFF, 16'hFFFF, 1'b1,
             sel(16'h8000, 2'd0, 8'd0, 1'b1, 1'b0));
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b1,
             sel(16'h7FFF, 2'd1, 8'd0, 1'b1, 1'b0));
    add_item(sbrr_pkg::CMD_ADVANCE, 16'hFFFF, 16'hFFFF, 1'b0, '0);
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0);  // wraps, passes entry 0
    // give every entry a skip amount, then a walk that skips them all
    add_item(sbrr_pkg::CMD_UPDATE, 16'h7FFF, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'h0000, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'hFFFF, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0);
    // small cap: doubling saturates, then sticks
    add_write(sbrr_pkg::REG_MAX_SKIP, 16'd3);
    add_item(sbrr_pkg::CMD_UPDATE, 16'hFFFF, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'hFFFF, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'hFFFF, 16'h0000, 1'b0, '0);
    // zero threshold: every count clears
    add_write(sbrr_pkg::REG_THRESHOLD, 16'd0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'hFFFF, 16'hFFFF, 1'b0, '0);
    // cap below an existing amount leaves it
    add_write(sbrr_pkg::REG_THRESHOLD, 16'd1);
    add_write(sbrr_pkg::REG_MAX_SKIP, 16'd0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'h0000, 16'h0000, 1'b0, '0);
    // zero entries acts as one; index beyond the entries in use
    add_write(sbrr_pkg::REG_ENTRIES, 16'd0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'hFFFF, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0);
    // too many entries saturates at the table size
    add_write(sbrr_pkg::REG_ENTRIES, 16'd7);
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0);
    // disabled with live skip amounts
    add_write(sbrr_pkg::REG_ENABLE, 16'd0);
    add_item(sbrr_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0);
    add_item(sbrr_pkg::CMD_UPDATE, 16'h8000, 16'h0000, 1'b0, '0);

    snd_idle_pct = 12;
    rcv_idle_pct = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_open = 1'b0;
    for (k = 0; k < directed_rows.size(); k++) begin
      r = directed_rows[k];
      if (r.kind == ROW_WRITE) begin
        if (!cfg_open) wait_idle();
        write_reg(r.addr, r.wdata);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we <= 1'b0;
        cfg_open = 1'b0;
        send_item(r.cmd, r.cv, r.cnt, r.typed, r.want);
      end
    end

    // random phases, each under fresh settings
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      snd_idle_pct = (phase < 4) ? 12 : (phase < 8) ? 50 : 0;
      rcv_idle_pct = (phase < 4) ? 50 : (phase < 8) ? 12 : 0;
      wait_idle();
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(3))
          0:       v = 16'($urandom);
          1:       v = 16'h8000;
          2:       v = 16'h7FFF;
          default: v = 16'($urandom_range(2));  // small values give duplicates
        endcase
        write_reg(sbrr_pkg::REG_CV_0 + 3'(i), v);
      end
      write_reg(sbrr_pkg::REG_ENTRIES,
                16'(($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(7)));
      case ($urandom_range(4))
        0:       v = 16'($urandom_range(1, 3));
        1:       v = 16'($urandom_range(4, 16));
        2:       v = 16'd255;
        3:       v = 16'($urandom_range(255));
        default: v = 16'd0;
      endcase
      write_reg(sbrr_pkg::REG_MAX_SKIP, v);
      case ($urandom_range(3))
        0:       v = 16'd0;
        1:       v = 16'hFFFF;
        default: v = 16'($urandom);
      endcase
      write_reg(sbrr_pkg::REG_THRESHOLD, v);
      write_reg(sbrr_pkg::REG_ENABLE, 16'((phase == 5) ? 0 : ($urandom_range(9) != 0)));
      cfg_we <= 1'b0;

      // long hold-off on the result side while items keep coming
      if (phase == 1) hold_requests++;

      repeat (ITEMS_PER_PHASE) begin
        cmd = 1'($urandom_range(1));
        // mostly voltages from the table, so updates land
        if ($urandom_range(3) != 0) cv = tbl_cv[2'($urandom_range(3))];
        else cv = 16'($urandom);
        pick = $urandom_range(9);
        if (pick < 4 && tbl_threshold != 0) cnt = 16'($urandom_range(tbl_threshold - 1, 0));
        else if (pick < 7) cnt = 16'($urandom_range(16'hFFFF, tbl_threshold));
        else cnt = 16'($urandom);
        send_item(cmd, cv, cnt, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
